>>> sv/lpb_pkg.sv
// Shared types and constants for the LED PWM breathing controller.
`default_nettype none

package lpb_pkg;

   localparam int unsigned PeriodWidth = 16;
   localparam int unsigned PortWidth   = 8;

   localparam logic [PeriodWidth-1:0] RESET_PERIOD = 16'd500;
   localparam logic [2:0]             TOP_BIT      = 3'd7;

   localparam logic [1:0] CSR_MODE        = 2'd0;
   localparam logic [1:0] CSR_LED_SELECT  = 2'd1;
   localparam logic [1:0] CSR_TICK_PERIOD = 2'd2;
   localparam logic [1:0] CSR_DUTY        = 2'd3;

   localparam logic MODE_FIXED     = 1'b0;
   localparam logic MODE_BREATHING = 1'b1;

   typedef struct packed {
      logic                   mode;
      logic [1:0]             led_select;
      logic [PeriodWidth-1:0] tick_period;
      logic [PeriodWidth-1:0] duty_threshold;
   } cfg_type;

   typedef struct packed {
      logic                 led_on;
      logic [PortWidth-1:0] port_bits;
   } result_type;

endpackage

`default_nettype wire

>>> sv/lpb_if.sv
// Request and response channel interfaces of the LED PWM breathing controller.
`default_nettype none

interface lpb_req_if;
   logic valid;
   logic ready;
   logic slow_tick;

   modport source (output valid, output slow_tick, input ready);
   modport sink (input valid, input slow_tick, output ready);
endinterface

interface lpb_rsp_if;
   logic       valid;
   logic       ready;
   logic       led_on;
   logic [7:0] port_bits;

   modport source (output valid, output led_on, output port_bits, input ready);
   modport sink (input valid, input led_on, input port_bits, output ready);
endinterface

`default_nettype wire

>>> sv/led_pwm_breathing_controller.sv
// Top level of the LED PWM breathing controller.
//
// Each request on req is one PWM tick; slow_tick marks a fade-rate event.
// Each request yields exactly one response on rsp: led_on for the selected
// LED and port_bits, the port image with only bit 7-2*led_select able to be
// set. The tick is processed in the cycle it is accepted and the response is
// held in an output register, so a response appears in the cycle after its
// request. One request is accepted per cycle; req.ready stays high while the
// output register is empty or being drained in the same cycle, so a stalled
// receiver stalls the request side only once the output register is full.
// The csr port writes mode, led_select, tick_period and duty_threshold by
// index; writes are meant for idle periods. Synchronous reset clears the
// counter and fade state, empties the output register and loads the register
// defaults (fixed mode, LED 0, period 500, duty 0). Nothing else needs to run
// after reset: the first request can be taken in the next cycle.
`default_nettype none

module led_pwm_breathing_controller
   import lpb_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   lpb_req_if.sink                     req,
   lpb_rsp_if.source                   rsp,
   input  wire logic                   csr_write_enable,
   input  wire logic [1:0]             csr_index,
   input  wire logic [PeriodWidth-1:0] csr_write_data
);

   cfg_type    cfg;
   result_type result;
   result_type rsp_data_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;

   lpb_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lpb_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .slow_tick (req.slow_tick),
      .result    (result)
   );

   assign req.ready    = !rsp_valid_ff || rsp.ready;
   assign accept       = req.valid && req.ready;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.led_on    = rsp_data_ff.led_on;
   assign rsp.port_bits = rsp_data_ff.port_bits;

   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp.valid)
      else $error("accepted request produced no response");

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ($countones(rsp.port_bits) == 32'(rsp.led_on)))
      else $error("port image disagrees with LED level");

   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.port_bits[0] == 1'b0) && (rsp.port_bits[2] == 1'b0)
                    && (rsp.port_bits[4] == 1'b0) && (rsp.port_bits[6] == 1'b0))
      else $error("LED drive on an even port bit");

endmodule

`default_nettype wire

>>> sv/lpb_csr.sv
// Configuration register file of the LED PWM breathing controller.
`default_nettype none

module lpb_csr
   import lpb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [1:0]             csr_index,
   input  wire logic [PeriodWidth-1:0] csr_write_data,
   output      cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE:        cfg_in.mode           = csr_write_data[0];
            CSR_LED_SELECT:  cfg_in.led_select     = csr_write_data[1:0];
            CSR_TICK_PERIOD: cfg_in.tick_period    = csr_write_data;
            CSR_DUTY:        cfg_in.duty_threshold = csr_write_data;
            default:         cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_FIXED;
         cfg_ff.led_select     <= 2'd0;
         cfg_ff.tick_period    <= RESET_PERIOD;
         cfg_ff.duty_threshold <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> sv/lpb_core.sv
// PWM counter, fade level state and LED decision for one tick.
`default_nettype none

module lpb_core
   import lpb_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = 16
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       accept,
   input  wire logic       slow_tick,
   output      result_type result
);

   localparam int unsigned CmpWidth = (COUNT_WIDTH > PeriodWidth) ? COUNT_WIDTH : PeriodWidth;

   logic [COUNT_WIDTH-1:0] counter_ff;
   logic [COUNT_WIDTH-1:0] counter_in;
   logic [PeriodWidth-1:0] level_ff;
   logic [PeriodWidth-1:0] level_in;
   logic                   falling_ff;
   logic                   falling_in;
   logic                   pending_ff;
   logic                   pending_in;

   logic [PeriodWidth-1:0] period_eff;
   logic [COUNT_WIDTH-1:0] count_cur;
   logic                   pending_now;
   logic                   do_step;
   logic [PeriodWidth:0]   level_moved;
   logic [PeriodWidth-1:0] level_stepped;
   logic                   falling_stepped;
   logic [PeriodWidth-1:0] duty_clipped;
   logic [PeriodWidth-1:0] threshold;
   logic                   led_on;
   logic [2:0]             bit_pos;

   always_comb begin
      period_eff = (cfg.tick_period == '0) ? PeriodWidth'(1) : cfg.tick_period;

      // The counter restarts whenever it has reached the period, also after
      // the period was made shorter.
      if (CmpWidth'(counter_ff) >= CmpWidth'(period_eff)) begin
         count_cur = '0;
      end else begin
         count_cur = counter_ff;
      end

      pending_now = pending_ff | slow_tick;
      do_step     = (cfg.mode == MODE_BREATHING) && (count_cur == '0) && pending_now;

      // One bounce step; the extra bit catches a rise past the top value.
      if (falling_ff) begin
         level_moved = (level_ff != '0) ? ({1'b0, level_ff} - (PeriodWidth+1)'(1)) : '0;
      end else begin
         level_moved = {1'b0, level_ff} + (PeriodWidth+1)'(1);
      end
      if (level_moved >= {1'b0, period_eff}) begin
         level_stepped   = period_eff;
         falling_stepped = 1'b1;
      end else if (level_moved == '0) begin
         level_stepped   = '0;
         falling_stepped = 1'b0;
      end else begin
         level_stepped   = level_moved[PeriodWidth-1:0];
         falling_stepped = falling_ff;
      end

      level_in   = do_step ? level_stepped : level_ff;
      falling_in = do_step ? falling_stepped : falling_ff;
      pending_in = do_step ? 1'b0 : pending_now;

      duty_clipped = (cfg.duty_threshold < period_eff) ? cfg.duty_threshold : period_eff;
      threshold    = (cfg.mode == MODE_BREATHING) ? level_in : duty_clipped;
      led_on       = CmpWidth'(count_cur) < CmpWidth'(threshold);
      counter_in   = count_cur + COUNT_WIDTH'(1);

      bit_pos          = TOP_BIT - {cfg.led_select, 1'b0};
      result.led_on    = led_on;
      result.port_bits = led_on ? (PortWidth'(1) << bit_pos) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         level_ff   <= '0;
         falling_ff <= 1'b0;
         pending_ff <= 1'b0;
      end else if (accept) begin
         counter_ff <= counter_in;
         level_ff   <= level_in;
         falling_ff <= falling_in;
         pending_ff <= pending_in;
      end
   end

   // The direction turns to falling only at a nonzero top, and back at zero.
   assert property (@(posedge clock) disable iff (reset)
      !(falling_ff && (level_ff == '0)))
      else $error("fade falling while level is zero");

   assert property (@(posedge clock) disable iff (reset)
      accept && do_step |=> !pending_ff)
      else $error("pending fade tick not consumed by a step");

   assert property (@(posedge clock) disable iff (reset)
      accept && (cfg.mode == MODE_FIXED) |=> $stable(level_ff) && $stable(falling_ff))
      else $error("fade state moved in fixed mode");

endmodule

`default_nettype wire
